/* src/unsigned_divide_32_by_16_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned divider
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DIVIDE_32_BY_16_MACROS_SVH
`define UNSIGNED_DIVIDE_32_BY_16_MACROS_SVH

// same-cycle implication
`define UD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/udiv_pkg.sv */
// ----------------------------------------------------------------------------
// udiv_pkg
// Widths and shared types for the unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

  localparam int DIVIDEND_BITS = 32;
  localparam int DIVISOR_BITS  = 16;

  // step counter holds DIVIDEND_BITS itself
  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  localparam int EXT_W = (DIVIDEND_BITS > DIVISOR_BITS) ? DIVIDEND_BITS : DIVISOR_BITS;

  typedef logic [DIVIDEND_BITS-1:0] dividend_t;
  typedef logic [DIVISOR_BITS-1:0]  divisor_t;
  typedef logic [CNT_W-1:0]         count_t;

  // controls broadcast to every remainder cell
  typedef struct packed {
    logic load;  // clear remainder bit, take divisor bit
    logic step;  // advance one quotient bit
    logic keep;  // trial subtraction succeeded
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/udiv_cell.sv */
// ----------------------------------------------------------------------------
// udiv_cell
// One bit slice of the partial remainder: holds a remainder bit and a divisor
// bit, forms one bit of the trial subtraction and shifts toward the MSB.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_cell (
  input  wire                        clk,
  input  wire udiv_pkg::cell_ctrl_t  ctrl,
  input  wire                        load_d,
  input  wire                        s_in,
  input  wire                        b_in,
  output logic                       r_o,
  output logic                       d_o,
  output logic                       b_out,
  output logic                       r_nxt_o
);
  import udiv_pkg::*;

  logic r_r;
  logic d_r;
  logic diff;

  assign diff    = s_in ^ d_r ^ b_in;
  assign b_out   = (~s_in & d_r) | (~s_in & b_in) | (d_r & b_in);
  assign r_nxt_o = ctrl.keep ? diff : s_in;
  assign r_o     = r_r;
  assign d_o     = d_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r_r <= 1'b0;
      d_r <= load_d;
    end else if (ctrl.step) begin
      r_r <= r_nxt_o;
    end
  end

endmodule

`default_nettype wire

/* src/unsigned_divide_32_by_16.sv */
// ----------------------------------------------------------------------------
// unsigned_divide_32_by_16
// Restoring divider: 32-bit unsigned dividend by 16-bit unsigned divisor.
// ----------------------------------------------------------------------------
// One word at a time. After a word is accepted the row of remainder cells
// produces one quotient bit per cycle, but the last bit waits while an
// untaken result fills the output register; the next word can be taken
// once the finished result is written there. The rate is set by the single
// trial subtraction across the cell row, once per dividend bit. A zero
// divisor skips the iteration: the result goes straight to the output
// register with divide_by_zero set, quotient 0 and remainder equal to the
// low 16 bits of the dividend. The result sits in an output register, so a
// new word is accepted while a finished one still waits to be taken.
`default_nettype none

module unsigned_divide_32_by_16 (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [udiv_pkg::DIVIDEND_BITS-1:0] in_dividend,
  input  wire  [udiv_pkg::DIVISOR_BITS-1:0]  in_divisor,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [udiv_pkg::DIVIDEND_BITS-1:0] out_quotient,
  output logic [udiv_pkg::DIVISOR_BITS-1:0]  out_remainder,
  output logic                       out_divide_by_zero
);
  import udiv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  count_t     count_r, count_nxt;
  logic       zero_r, zero_nxt;
  dividend_t  qr_r, qr_nxt;
  logic       out_valid_r, out_valid_nxt;
  dividend_t  quo_r;
  divisor_t   rem_r;
  logic       dz_r;

  cell_ctrl_t ctrl;
  divisor_t   r_w, d_w, b_w, rn_w;
  logic       accept, slot_free, last, step, fin, q_bit;
  logic [EXT_W-1:0] qr_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign slot_free = ~out_valid_r | out_ready;
  assign last      = (count_r == CNT_W'(1));
  assign step      = (state_r == ST_RUN) & ~zero_r & (~last | slot_free);
  assign fin       = (state_r == ST_RUN) & (zero_r | last) & slot_free;

  // borrow out of the extended top bit decides the quotient bit
  assign q_bit = ~(~r_w[DIVISOR_BITS-1] & b_w[DIVISOR_BITS-1]);

  assign ctrl = '{load: accept, step: step, keep: q_bit};

  for (genvar i = 0; i < DIVISOR_BITS; i++) begin : g_cell
    if (i == 0) begin : g_lsb
      udiv_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .load_d  (in_divisor[i]),
        .s_in    (qr_r[DIVIDEND_BITS-1]),
        .b_in    (1'b0),
        .r_o     (r_w[i]),
        .d_o     (d_w[i]),
        .b_out   (b_w[i]),
        .r_nxt_o (rn_w[i])
      );
    end else begin : g_mid
      udiv_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .load_d  (in_divisor[i]),
        .s_in    (r_w[i-1]),
        .b_in    (b_w[i-1]),
        .r_o     (r_w[i]),
        .d_o     (d_w[i]),
        .b_out   (b_w[i]),
        .r_nxt_o (rn_w[i])
      );
    end
  end

  assign qr_ext = EXT_W'(qr_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    zero_nxt      = zero_r;
    qr_nxt        = qr_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          count_nxt = CNT_W'(DIVIDEND_BITS);
          zero_nxt  = (in_divisor == '0);
          qr_nxt    = in_dividend;
        end
      end
      ST_RUN: begin
        if (step) begin
          qr_nxt    = {qr_r[DIVIDEND_BITS-2:0], q_bit};
          count_nxt = count_r - CNT_W'(1);
        end
        if (fin) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qr_r <= qr_nxt;
    if (fin) begin
      dz_r <= zero_r;
      if (zero_r) begin
        quo_r <= '0;
        rem_r <= qr_ext[DIVISOR_BITS-1:0];
      end else begin
        quo_r <= qr_nxt;
        rem_r <= rn_w;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = quo_r;
  assign out_remainder      = rem_r;
  assign out_divide_by_zero = dz_r;

`include "unsigned_divide_32_by_16_macros.svh"

  `UD_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "divider ready right after accept")
  `UD_ASSERT_NOW(a_zero_quotient, out_valid_r && dz_r, out_quotient == '0,
                 "nonzero quotient on divide by zero")
  `UD_ASSERT_NOW(a_rem_below_div, out_valid_r && !dz_r && state_r == ST_IDLE,
                 out_remainder < d_w, "remainder not below divisor")
  `UD_ASSERT_NOW(a_count_live, state_r == ST_RUN && !zero_r, count_r != '0,
                 "step counter ran out while running")

endmodule

`default_nettype wire

/* verif/tb_unsigned_divide_32_by_16.sv */
// ----------------------------------------------------------------------------
// tb_unsigned_divide_32_by_16
// Self-checking bench for the 32 by 16 unsigned divider. A queue of operand
// words feeds a valid/ready driver; each accepted word is run through a
// behavioral divide to give the expected quotient, remainder and zero-divisor
// flag, and a monitor compares every result word against the oldest one.
// Directed corner words come first, then random words in stretches with no
// idling, a slow sender, a stalling receiver and both together.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_unsigned_divide_32_by_16;

  import udiv_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_WORDS   = 1030;
  localparam int STRETCH_WORDS  = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 40;

  typedef enum int {
    PH_NO_IDLE,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  typedef struct {
    dividend_t dividend;
    divisor_t  divisor;
    int        idle_pct;
    int        stall_pct;
    bit        hold_for_drain;
  } operand_word_t;

  typedef struct {
    dividend_t dividend;
    divisor_t  divisor;
    dividend_t quotient;
    divisor_t  remainder;
    logic      divide_by_zero;
  } quot_rem_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dividend_t in_dividend = '0;
  divisor_t  in_divisor = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dividend_t out_quotient;
  divisor_t  out_remainder;
  logic      out_divide_by_zero;

  operand_word_t pending_words[$];
  quot_rem_t     expected_results[$];

  int stall_pct = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int zero_divisor_seen = 0;

  unsigned_divide_32_by_16 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_quotient      (out_quotient),
    .out_remainder     (out_remainder),
    .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic quot_rem_t divide_operands(dividend_t n, divisor_t d);
    quot_rem_t r;
    r.dividend = n;
    r.divisor  = d;
    if (d == '0) begin
      r.quotient       = '0;
      r.remainder      = n[DIVISOR_BITS-1:0];
      r.divide_by_zero = 1'b1;
    end else begin
      r.quotient       = n / {{(DIVIDEND_BITS-DIVISOR_BITS){1'b0}}, d};
      r.remainder      = divisor_t'(n % {{(DIVIDEND_BITS-DIVISOR_BITS){1'b0}}, d});
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  function automatic operand_word_t make_word(dividend_t n, divisor_t d, idle_phase_e ph,
                                              bit hold);
    operand_word_t w;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 86, 0, 35};
    stall_tab = '{0, 0, 86, 35};
    w.dividend       = n;
    w.divisor        = d;
    w.idle_pct       = idle_tab[ph];
    w.stall_pct      = stall_tab[ph];
    w.hold_for_drain = hold;
    return w;
  endfunction

  function automatic operand_word_t random_word(idle_phase_e ph, bit hold);
    dividend_t n;
    divisor_t  d;
    case ($urandom_range(9))
      0:       d = '0;
      1:       d = divisor_t'($urandom_range(1, 15));
      2:       d = divisor_t'(1) << $urandom_range(DIVISOR_BITS-1);
      3:       d = $urandom_range(1) ? 16'hFFFF : 16'h8000;
      default: d = divisor_t'($urandom);
    endcase
    n = dividend_t'($urandom);
    case ($urandom_range(9))
      6: n = dividend_t'($urandom_range(0, 32'h0001_FFFF));
      7: n = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      8: if (d != '0) n = n - n % d;
      9: if (d != '0) n = n - n % d + d - 1;
      default: ;
    endcase
    return make_word(n, d, ph, hold);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want, input quot_rem_t ref_word);
    error_count++;
    $display("ERROR: %s got 0x%08h want 0x%08h (dividend 0x%08h divisor 0x%04h)",
             what, got, want, ref_word.dividend, ref_word.divisor);
  endtask

  // driver
  always @(posedge clk) begin
    operand_word_t nxt;
    bit go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(divide_operands(in_dividend, in_divisor));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        go = 1'b0;
        if (pending_words.size() != 0) begin
          nxt = pending_words[0];
          go = ($urandom_range(99) >= nxt.idle_pct);
          if (nxt.hold_for_drain && (in_valid || expected_results.size() != 0)) go = 1'b0;
        end
        if (go) begin
          void'(pending_words.pop_front());
          in_valid    <= 1'b1;
          in_dividend <= nxt.dividend;
          in_divisor  <= nxt.divisor;
          stall_pct   <= nxt.stall_pct;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quot_rem_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          want = divide_operands('0, '0);
          report_mismatch("result word with nothing pending, quotient", out_quotient, 0, want);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.divide_by_zero) zero_divisor_seen++;
          if (out_quotient !== want.quotient)
            report_mismatch("quotient", out_quotient, want.quotient, want);
          if (out_remainder !== want.remainder)
            report_mismatch("remainder", 32'(out_remainder), 32'(want.remainder), want);
          if (out_divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero),
                            32'(want.divide_by_zero), want);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: cycles with no handshake on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    quot_rem_t leftover;
    idle_phase_e ph;

    // corners: zero divisor, extremes, dividend below divisor, exact multiples
    pending_words.push_back(make_word(32'h0000_0000, 16'h0000, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_FFFF, 16'h0000, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h1234_ABCD, 16'h0000, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_0000, 16'h0001, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_FFFF, 16'h0001, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_FFFF, 16'hFFFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_FFFF, 16'hFFFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_FFFE, 16'hFFFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_0001, 16'hFFFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h8000_0000, 16'h8000, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_FFFF, 16'h8000, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_FFFF, 16'h0002, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h7FFF_FFFF, 16'h7FFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hFFFF_0000, 16'hFFFF, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0001_0000, 16'h0001, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_0064, 16'h000A, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_0063, 16'h000A, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h00BC_614E, 16'h04D2, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'hAAAA_AAAA, 16'h5555, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h5555_5555, 16'hAAAA, PH_NO_IDLE, 1'b0));
    pending_words.push_back(make_word(32'h0000_FFFF, 16'h0000, PH_NO_IDLE, 1'b0));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      ph = idle_phase_e'((i / STRETCH_WORDS) % 4);
      pending_words.push_back(random_word(ph, (i % STRETCH_WORDS) == 0));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    while (expected_results.size() != 0) begin
      leftover = expected_results.pop_front();
      report_mismatch("missing result, quotient", 0, leftover.quotient, leftover);
    end

    $display("Sent %0d words, checked %0d results (%0d with a zero divisor)",
             words_sent, results_checked, zero_divisor_seen);
    $display("Covered corner operands plus random words under no, sender, receiver and %s",
             "mixed idling");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/udiv_pkg.sv
src/udiv_cell.sv
src/unsigned_divide_32_by_16.sv
verif/tb_unsigned_divide_32_by_16.sv
